FILE: hw/rtl/twrc_pkg.sv
// Shared types, constants and helper functions of the TFTP write-request checker.
package twrc_pkg;

    localparam int unsigned DATA_W = 8;

    localparam logic [DATA_W-1:0] BYTE_ZERO     = 8'h00;
    localparam logic [DATA_W-1:0] OPCODE_WRITE  = 8'h02;
    localparam logic [DATA_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [DATA_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [DATA_W-1:0] CASE_OFFSET   = 8'h20;

    // Parse position; the one unused code behaves like POS_REJECT.
    typedef enum logic [3:0] {
        POS_OP0       = 4'd0,
        POS_OP1       = 4'd1,
        POS_FN_FIRST  = 4'd2,
        POS_FN_REST   = 4'd3,
        POS_MODE0     = 4'd4,
        POS_MODE1     = 4'd5,
        POS_MODE2     = 4'd6,
        POS_MODE3     = 4'd7,
        POS_MODE4     = 4'd8,
        POS_MODE_END  = 4'd9,
        POS_OPT_IDLE  = 4'd10,
        POS_NAME_REST = 4'd11,
        POS_VAL_FIRST = 4'd12,
        POS_VAL_REST  = 4'd13,
        POS_REJECT    = 4'd14
    } t_parse_pos;

    // Expected lower-case letter of the transfer mode "octet" at each position.
    function automatic logic [DATA_W-1:0] mode_letter(input logic [2:0] idx);
        logic [DATA_W-1:0] letter;
        case (idx)
            3'd0:    letter = 8'h6F;
            3'd1:    letter = 8'h63;
            3'd2:    letter = 8'h74;
            3'd3:    letter = 8'h65;
            3'd4:    letter = 8'h74;
            default: letter = 8'h00;
        endcase
        return letter;
    endfunction

    // Folds ASCII upper-case letters to lower case and leaves other bytes alone.
    function automatic logic [DATA_W-1:0] fold_lower(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] folded;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            folded = b + CASE_OFFSET;
        end else begin
            folded = b;
        end
        return folded;
    endfunction

endpackage

FILE: hw/rtl/twrc_ifs.sv
// Valid/ready channel interfaces for request bytes and check results.
interface twrc_byte_if;
    logic                        valid;
    logic                        ready;
    logic [twrc_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface twrc_result_if;
    logic valid;
    logic ready;
    logic accepted;

    modport source (output valid, output accepted, input ready);
    modport sink   (input valid, input accepted, output ready);
endinterface

FILE: hw/rtl/tftp_write_request_checker.sv
// Top level of the TFTP write-request checker: byte register, parser state and result register.
//
//  Channel   Direction  Payload                 Beats
//  i_in      sink       data_byte[7:0], last    one per request payload byte
//  o_out     source     accepted                one per packet, after its last byte
//
// Every byte is first captured in the input register, and the parser state then
// steps through one small case decode of that byte.
// A new byte can be taken in every cycle, also while a result waits in the output
// register; only a last byte that finds the result register still full waits there.
// Reset (i_rst_n low, synchronous) empties both registers and sets the parser to
// expect the first opcode byte.
// A stalled output holds its result stable until it is taken.
module tftp_write_request_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    twrc_byte_if.sink   i_in,
    twrc_result_if.source o_out
);

    // Input register. A byte sitting here is consumed once the parser can take it.
    logic                        r_s1_valid;
    logic [twrc_pkg::DATA_W-1:0] r_s1_byte;
    logic                        r_s1_last;

    // Parser state and the result register.
    twrc_pkg::t_parse_pos r_pos;
    twrc_pkg::t_parse_pos n_pos;
    logic                 r_out_valid;
    logic                 r_accepted;

    logic                 s1_advance;
    logic                 out_take;
    logic [3:0]           mode_offset;
    logic [2:0]           mode_idx;

    // A byte that is not last only changes state, so it never waits on the output.
    // A last byte needs the result register empty or being emptied this cycle.
    assign out_take   = r_out_valid && o_out.ready;
    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.accepted = r_accepted;

    assign mode_offset = r_pos - twrc_pkg::POS_MODE0;
    assign mode_idx    = mode_offset[2:0];

    // Next parse position for the byte in the input register.
    always_comb begin
        unique case (r_pos) inside
            twrc_pkg::POS_OP0: begin
                n_pos = (r_s1_byte == twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_OP1
                                                           : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_OP1: begin
                n_pos = (r_s1_byte == twrc_pkg::OPCODE_WRITE) ? twrc_pkg::POS_FN_FIRST
                                                              : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_FN_FIRST: begin
                n_pos = (r_s1_byte != twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_FN_REST
                                                           : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_FN_REST: begin
                n_pos = (r_s1_byte == twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_MODE0
                                                           : twrc_pkg::POS_FN_REST;
            end
            twrc_pkg::POS_MODE0, twrc_pkg::POS_MODE1, twrc_pkg::POS_MODE2,
            twrc_pkg::POS_MODE3, twrc_pkg::POS_MODE4: begin
                // Mode letters compare case-insensitively against "octet".
                if (twrc_pkg::fold_lower(r_s1_byte) == twrc_pkg::mode_letter(mode_idx)) begin
                    n_pos = twrc_pkg::t_parse_pos'(r_pos + 4'd1);
                end else begin
                    n_pos = twrc_pkg::POS_REJECT;
                end
            end
            twrc_pkg::POS_MODE_END: begin
                n_pos = (r_s1_byte == twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_OPT_IDLE
                                                           : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_OPT_IDLE: begin
                n_pos = (r_s1_byte != twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_NAME_REST
                                                           : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_NAME_REST: begin
                n_pos = (r_s1_byte == twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_VAL_FIRST
                                                           : twrc_pkg::POS_NAME_REST;
            end
            twrc_pkg::POS_VAL_FIRST: begin
                n_pos = (r_s1_byte != twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_VAL_REST
                                                           : twrc_pkg::POS_REJECT;
            end
            twrc_pkg::POS_VAL_REST: begin
                n_pos = (r_s1_byte == twrc_pkg::BYTE_ZERO) ? twrc_pkg::POS_OPT_IDLE
                                                           : twrc_pkg::POS_VAL_REST;
            end
            default: begin
                // The rejected position and the unused code both stay rejected.
                n_pos = twrc_pkg::POS_REJECT;
            end
        endcase
    end

    // Input register: loads whenever the channel hands over a beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    // Parser state: a last byte always returns the parser to the first opcode byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= twrc_pkg::POS_OP0;
        end else if (s1_advance) begin
            r_pos <= r_s1_last ? twrc_pkg::POS_OP0 : n_pos;
        end
    end

    // Result register: a packet is accepted only if its last byte leaves the parser
    // between option pairs, which means a complete request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_last) begin
            r_accepted <= (n_pos == twrc_pkg::POS_OPT_IDLE);
        end
    end

    // A last byte restarts the parser and leaves a result behind.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_last |=> r_pos == twrc_pkg::POS_OP0 && r_out_valid)
        else $error("last byte did not restart the parser or produce a result");

    // Once rejected, a packet stays rejected until its last byte.
    a_reject_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == twrc_pkg::POS_REJECT && s1_advance && !r_s1_last
        |=> r_pos == twrc_pkg::POS_REJECT)
        else $error("parser left the rejected position before the last byte");

    // An empty input register always takes a beat.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> i_in.ready)
        else $error("input not ready while the input register is empty");

    // A result that is not taken is never overwritten by the next packet.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(s1_advance && r_s1_last))
        else $error("result register overwritten while still full");

endmodule
